>>> hw/rtl/stff_pkg.sv
// types and constants shared by the slot table with first-free allocation
`default_nettype none

package stff_pkg;

    // operation codes carried in the func field
    typedef enum logic [2:0] {
        FN_ADD     = 3'd0,
        FN_SWAP    = 3'd1,
        FN_REPLACE = 3'd2,
        FN_REMOVE  = 3'd3,
        FN_CLEAR   = 3'd4,
        FN_CHECK   = 3'd5
    } t_func;

    // result kinds
    localparam logic KIND_CHANGE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // field widths of the channels
    localparam int FUNC_W   = 3;
    localparam int HANDLE_W = 16;
    localparam int INDEX_W  = 4;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    // sequencer states
    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_DECODE  = 12'b0000_0000_0010,
        ST_SCAN    = 12'b0000_0000_0100,
        ST_CLEAR   = 12'b0000_0000_1000,
        ST_READ_A  = 12'b0000_0001_0000,
        ST_READ_B  = 12'b0000_0010_0000,
        ST_SWAP_WA = 12'b0000_0100_0000,
        ST_SWAP_WB = 12'b0000_1000_0000,
        ST_REP_WR  = 12'b0001_0000_0000,
        ST_CHG_A   = 12'b0010_0000_0000,
        ST_CHG_B   = 12'b0100_0000_0000,
        ST_STATUS  = 12'b1000_0000_0000
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/slot_table_first_free_top.sv
// slot table with first-free add, swap, replace, remove, clear and check
//
// Items enter on the s_axis channel; each one runs to completion before the
// next is taken (s_axis_tready is high only while the sequencer is idle).
// Results leave on m_axis: zero or more change results (tuser 0), one per
// written slot while notify is on, then one status result (tuser 1, tlast 1).
// The 1-bit notify register is written on the cfg channel, always ready.
// Steps per item: accept (idle) and decode, then
//   add      scan slot by slot up to the first free slot, +1 change
//   swap     read A, read B, write A, write B, +2 changes
//   replace  read A, then write, +1 change
//   remove   +1 change; check and unused codes nothing more
//   clear    visit every slot
// and last the status result. The slot memory has one read and one
// write port; the single scan counter walks the occupancy bits one slot per
// cycle for add and clear, clear stalling while a change waits for output. A
// one-entry output register holds each result; a stalled receiver simply
// holds the sequencer at its next result. Reset empties every slot at once
// through per-slot occupancy bits, zeroes the count and sets notify.
`default_nettype none

module slot_table_first_free_top #(
    parameter int SLOT_COUNT = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // func[2:0], item_handle[18:3], first_index[22:19], second_index[26:23]
    input  wire  [31:0] s_axis_tdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[3:0], handle_out[19:4], ok[20], count[25:21], full_res[26]
    output logic [31:0] m_axis_tdata,
    // kind[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_data
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(SLOT_COUNT);

    // latched item
    logic [stff_pkg::FUNC_W-1:0]   r_func;
    logic [stff_pkg::HANDLE_W-1:0] r_h;
    logic [stff_pkg::INDEX_W-1:0]  r_a;
    logic [stff_pkg::INDEX_W-1:0]  r_b;

    stff_pkg::t_state r_state, n_state;
    logic [SLOT_COUNT-1:0] r_occ;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_notify;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_two, n_two;
    logic [IW-1:0]         r_st_slot, n_st_slot;
    logic [15:0]           r_st_h, n_st_h;
    logic                  r_ok, n_ok;
    logic [15:0]           r_ha, n_ha;
    logic [IW-1:0]         r_ca_slot, n_ca_slot, r_cb_slot, n_cb_slot;
    logic [15:0]           r_ca_h, n_ca_h, r_cb_h, n_cb_h;

    // slot memory, valid only where the occupancy bit is set
    logic [15:0]   r_mem [SLOT_COUNT];
    logic [15:0]   r_rd_data;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [15:0]   mem_wd;

    logic          occ_we;
    logic [IW-1:0] occ_wa;
    logic          occ_wd;

    // output register
    logic        r_out_valid;
    logic        r_out_kind, r_out_ok, r_out_last, r_out_full;
    logic [3:0]  r_out_slot;
    logic [15:0] r_out_h;
    logic [4:0]  r_out_cnt;

    logic        emit;
    logic        e_kind, e_ok, e_last;
    logic [3:0]  e_slot;
    logic [15:0] e_h;

    logic          out_free;
    logic [IW-1:0] ia, ib;
    logic          a_ok, b_ok;
    logic          occ_a, occ_b, occ_i;
    logic          s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign ia       = IW'(r_a);
    assign ib       = IW'(r_b);
    assign a_ok     = 32'(r_a) < SLOT_COUNT;
    assign b_ok     = 32'(r_b) < SLOT_COUNT;
    assign occ_a    = r_occ[ia];
    assign occ_b    = r_occ[ib];
    assign occ_i    = r_occ[r_idx];
    assign rd_addr  = (r_state == stff_pkg::ST_READ_B) ? ib : ia;

    assign s_axis_tready = (r_state == stff_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_two     = r_two;
        n_st_slot = r_st_slot;
        n_st_h    = r_st_h;
        n_ok      = r_ok;
        n_ha      = r_ha;
        n_ca_slot = r_ca_slot;
        n_ca_h    = r_ca_h;
        n_cb_slot = r_cb_slot;
        n_cb_h    = r_cb_h;
        mem_we    = 1'b0;
        mem_wa    = ia;
        mem_wd    = r_h;
        occ_we    = 1'b0;
        occ_wa    = ia;
        occ_wd    = 1'b0;
        emit      = 1'b0;
        e_kind    = stff_pkg::KIND_CHANGE;
        e_slot    = 4'(r_ca_slot);
        e_h       = r_ca_h;
        e_ok      = 1'b0;
        e_last    = 1'b0;

        unique case (r_state)
            stff_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = stff_pkg::ST_DECODE;
                end
            end
            stff_pkg::ST_DECODE: begin
                n_st_slot = '0;
                n_st_h    = '0;
                n_ok      = 1'b0;
                n_two     = (r_func == stff_pkg::FN_SWAP);
                n_state   = stff_pkg::ST_STATUS;
                unique case (r_func)
                    stff_pkg::FN_ADD: begin
                        if (r_h != '0 && r_cnt < CNT_FULL) begin
                            n_idx   = '0;
                            n_state = stff_pkg::ST_SCAN;
                        end
                    end
                    stff_pkg::FN_SWAP: begin
                        if (a_ok && b_ok) begin
                            n_state = stff_pkg::ST_READ_A;
                        end
                    end
                    stff_pkg::FN_REPLACE: begin
                        if (a_ok) begin
                            n_state = stff_pkg::ST_READ_A;
                        end
                    end
                    stff_pkg::FN_REMOVE: begin
                        if (a_ok) begin
                            occ_we    = 1'b1;
                            n_cnt     = r_cnt - CW'(occ_a);
                            n_ca_slot = ia;
                            n_ca_h    = '0;
                            n_state   = stff_pkg::ST_CHG_A;
                        end
                    end
                    stff_pkg::FN_CLEAR: begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = stff_pkg::ST_CLEAR;
                    end
                    stff_pkg::FN_CHECK: begin
                        n_ok = a_ok && occ_a;
                    end
                    default: begin
                        n_state = stff_pkg::ST_STATUS;
                    end
                endcase
            end
            stff_pkg::ST_SCAN: begin
                if (!occ_i) begin
                    mem_we    = 1'b1;
                    mem_wa    = r_idx;
                    occ_we    = 1'b1;
                    occ_wa    = r_idx;
                    occ_wd    = 1'b1;
                    n_cnt     = r_cnt + CW'(1);
                    n_st_slot = r_idx;
                    n_ok      = 1'b1;
                    n_ca_slot = r_idx;
                    n_ca_h    = r_h;
                    n_state   = stff_pkg::ST_CHG_A;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            stff_pkg::ST_CLEAR: begin
                e_slot = 4'(r_idx);
                e_h    = '0;
                // an occupied slot with notify on waits for the output register
                if (!occ_i || !r_notify || out_free) begin
                    emit   = occ_i && r_notify;
                    occ_we = 1'b1;
                    occ_wa = r_idx;
                    if (r_idx == IDX_LAST) begin
                        n_state = stff_pkg::ST_STATUS;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            stff_pkg::ST_READ_A: begin
                n_state = r_two ? stff_pkg::ST_READ_B : stff_pkg::ST_REP_WR;
            end
            stff_pkg::ST_READ_B: begin
                n_ha    = occ_a ? r_rd_data : '0;
                n_state = stff_pkg::ST_SWAP_WA;
            end
            stff_pkg::ST_SWAP_WA: begin
                mem_we    = 1'b1;
                mem_wd    = occ_b ? r_rd_data : '0;
                occ_we    = 1'b1;
                occ_wd    = occ_b && (r_rd_data != '0);
                n_ca_slot = ia;
                n_ca_h    = occ_b ? r_rd_data : '0;
                n_cb_slot = ib;
                n_cb_h    = r_ha;
                n_state   = stff_pkg::ST_SWAP_WB;
            end
            stff_pkg::ST_SWAP_WB: begin
                mem_we  = 1'b1;
                mem_wa  = ib;
                mem_wd  = r_ha;
                occ_we  = 1'b1;
                occ_wa  = ib;
                occ_wd  = (r_ha != '0);
                n_state = stff_pkg::ST_CHG_A;
            end
            stff_pkg::ST_REP_WR: begin
                n_st_h    = occ_a ? r_rd_data : '0;
                mem_we    = 1'b1;
                occ_we    = 1'b1;
                occ_wd    = (r_h != '0);
                n_cnt     = r_cnt + CW'(r_h != '0) - CW'(occ_a);
                n_ca_slot = ia;
                n_ca_h    = r_h;
                n_state   = stff_pkg::ST_CHG_A;
            end
            stff_pkg::ST_CHG_A: begin
                if (!r_notify || out_free) begin
                    emit    = r_notify;
                    n_state = r_two ? stff_pkg::ST_CHG_B : stff_pkg::ST_STATUS;
                end
            end
            stff_pkg::ST_CHG_B: begin
                e_slot = 4'(r_cb_slot);
                e_h    = r_cb_h;
                if (!r_notify || out_free) begin
                    emit    = r_notify;
                    n_state = stff_pkg::ST_STATUS;
                end
            end
            stff_pkg::ST_STATUS: begin
                e_kind = stff_pkg::KIND_STATUS;
                e_slot = 4'(r_st_slot);
                e_h    = r_st_h;
                e_ok   = r_ok;
                e_last = 1'b1;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = stff_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stff_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stff_pkg::ST_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_notify    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (occ_we) begin
                r_occ[occ_wa] <= occ_wd;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_notify <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func <= s_axis_tdata[2:0];
            r_h    <= s_axis_tdata[18:3];
            r_a    <= s_axis_tdata[22:19];
            r_b    <= s_axis_tdata[26:23];
        end
        r_idx     <= n_idx;
        r_two     <= n_two;
        r_st_slot <= n_st_slot;
        r_st_h    <= n_st_h;
        r_ok      <= n_ok;
        r_ha      <= n_ha;
        r_ca_slot <= n_ca_slot;
        r_ca_h    <= n_ca_h;
        r_cb_slot <= n_cb_slot;
        r_cb_h    <= n_cb_h;
        if (emit) begin
            r_out_kind <= e_kind;
            r_out_slot <= e_slot;
            r_out_h    <= e_h;
            r_out_ok   <= e_ok;
            r_out_last <= e_last;
            // count and full always reflect the state after the whole item
            r_out_cnt  <= 5'(r_cnt);
            r_out_full <= (r_cnt == CNT_FULL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'b0, r_out_full, r_out_cnt, r_out_ok, r_out_h, r_out_slot};

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("occupied count above table size");

    a_cnt_matches_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stff_pkg::ST_IDLE) |-> (r_cnt == CW'($countones(r_occ))))
        else $error("occupied count out of step with occupancy bits");

    a_scan_finds_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stff_pkg::ST_SCAN && r_idx == IDX_LAST) |-> !occ_i)
        else $error("add scan reached the end without a free slot");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_kind == stff_pkg::KIND_STATUS)))
        else $error("last flag and result kind disagree");

    a_status_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stff_pkg::ST_STATUS && out_free) |=> (r_state == stff_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after status");

endmodule

`default_nettype wire

>>> dv/slot_table_first_free_top_tb.sv
// self-checking testbench for the slot table: predicts every change and status item
`default_nettype none

module slot_table_first_free_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = 16;
    localparam int IDLE_PCT = 28;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [stff_pkg::FUNC_W-1:0] FN_UNUSED_LO = 3'd6;
    localparam logic [stff_pkg::FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

    // packed from the top bit down, so func lands in the lowest bits of tdata
    typedef struct packed {
        logic [stff_pkg::INDEX_W-1:0]  idx_b;
        logic [stff_pkg::INDEX_W-1:0]  idx_a;
        logic [stff_pkg::HANDLE_W-1:0] handle;
        logic [stff_pkg::FUNC_W-1:0]   func;
    } t_table_op;

    typedef struct {
        logic                          kind;
        logic [stff_pkg::SLOT_W-1:0]   slot;
        logic [stff_pkg::HANDLE_W-1:0] handle;
        logic                          ok;
        logic [stff_pkg::COUNT_W-1:0]  count;
        logic                          full;
        logic                          last;
    } t_table_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    slot_table_first_free_top #(
        .SLOT_COUNT(TABLE_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the table
    logic [stff_pkg::HANDLE_W-1:0] slot_shadow [TABLE_SLOTS];
    logic [stff_pkg::COUNT_W-1:0]  occupied_shadow = '0;
    logic                          notify_shadow = 1'b1;

    t_table_op     pending_ops[$];
    t_table_result table_results_due[$];
    t_table_result slot_changes[$];
    bit            mismatch_seen = 1'b0;
    bit            no_idle = 1'b0;
    int            hold_req = 0;
    int            hold_left = 0;

    initial begin
        foreach (slot_shadow[i]) slot_shadow[i] = '0;
    end

    function automatic void store_slot(int idx, logic [stff_pkg::HANDLE_W-1:0] h);
        if (slot_shadow[idx] != 0 && h == 0) occupied_shadow = occupied_shadow - 1'b1;
        else if (slot_shadow[idx] == 0 && h != 0) occupied_shadow = occupied_shadow + 1'b1;
        slot_shadow[idx] = h;
    endfunction

    function automatic void note_change(int idx, logic [stff_pkg::HANDLE_W-1:0] h);
        t_table_result chg;
        if (notify_shadow) begin
            chg = '{kind: stff_pkg::KIND_CHANGE, slot: idx[stff_pkg::SLOT_W-1:0], handle: h,
                    ok: 1'b0, count: '0, full: 1'b0, last: 1'b0};
            slot_changes.push_back(chg);
        end
    endfunction

    function automatic void predict_table_op(t_table_op op);
        t_table_result status;
        logic [stff_pkg::HANDLE_W-1:0] held;
        bit placed;
        int i;
        status = '{kind: stff_pkg::KIND_STATUS, slot: '0, handle: '0, ok: 1'b0,
                   count: '0, full: 1'b0, last: 1'b1};
        slot_changes.delete();
        placed = 1'b0;
        case (op.func)
            stff_pkg::FN_ADD: begin
                if (op.handle != 0 && occupied_shadow < TABLE_SLOTS) begin
                    for (i = 0; i < TABLE_SLOTS; i++) begin
                        if (!placed && slot_shadow[i] == 0) begin
                            store_slot(i, op.handle);
                            note_change(i, op.handle);
                            status.slot = i[stff_pkg::SLOT_W-1:0];
                            status.ok = 1'b1;
                            placed = 1'b1;
                        end
                    end
                end
            end
            stff_pkg::FN_SWAP: begin
                if (op.idx_a < TABLE_SLOTS && op.idx_b < TABLE_SLOTS) begin
                    held = slot_shadow[op.idx_a];
                    slot_shadow[op.idx_a] = slot_shadow[op.idx_b];
                    slot_shadow[op.idx_b] = held;
                    note_change(op.idx_a, slot_shadow[op.idx_a]);
                    note_change(op.idx_b, slot_shadow[op.idx_b]);
                end
            end
            stff_pkg::FN_REPLACE: begin
                if (op.idx_a < TABLE_SLOTS) begin
                    status.handle = slot_shadow[op.idx_a];
                    store_slot(op.idx_a, op.handle);
                    note_change(op.idx_a, op.handle);
                end
            end
            stff_pkg::FN_REMOVE: begin
                if (op.idx_a < TABLE_SLOTS) begin
                    store_slot(op.idx_a, '0);
                    note_change(op.idx_a, '0);
                end
            end
            stff_pkg::FN_CLEAR: begin
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (slot_shadow[i] != 0) begin
                        slot_shadow[i] = '0;
                        note_change(i, '0);
                    end
                end
                occupied_shadow = '0;
            end
            stff_pkg::FN_CHECK: begin
                if (op.idx_a < TABLE_SLOTS) status.ok = slot_shadow[op.idx_a] != 0;
            end
            default: ;
        endcase
        // count and full reflect the table after the whole operation
        foreach (slot_changes[i]) begin
            slot_changes[i].count = occupied_shadow;
            slot_changes[i].full = occupied_shadow == TABLE_SLOTS;
            table_results_due.push_back(slot_changes[i]);
        end
        status.count = occupied_shadow;
        status.full = occupied_shadow == TABLE_SLOTS;
        table_results_due.push_back(status);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    function automatic void check_table_result(logic [31:0] data, logic kind, logic last);
        t_table_result want;
        if (table_results_due.size() == 0) begin
            $display("%0t: unexpected item, expected none actual kind %0d data %h last %0d",
                     $time, kind, data, last);
            mismatch_seen = 1'b1;
        end else begin
            want = table_results_due.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("slot", want.slot, data[3:0]);
            compare_field("handle_out", want.handle, data[19:4]);
            compare_field("ok", want.ok, data[20]);
            compare_field("count", want.count, data[25:21]);
            compare_field("full_res", want.full, data[26]);
            compare_field("last", want.last, last);
        end
    endfunction

    // sender: holds an item until taken, predicts it at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_table_op(pending_ops.pop_front());
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, pending_ops[0]};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_table_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [stff_pkg::HANDLE_W-1:0] random_handle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) return '1;
        if (roll < 20) return 16'h0001;
        return 16'($urandom_range(65535));
    endfunction

    function automatic t_table_op make_op(logic [stff_pkg::FUNC_W-1:0] func,
                                          logic [stff_pkg::HANDLE_W-1:0] h, int a, int b);
        t_table_op op;
        op.func = func;
        op.handle = h;
        op.idx_a = a[stff_pkg::INDEX_W-1:0];
        op.idx_b = b[stff_pkg::INDEX_W-1:0];
        return op;
    endfunction

    function automatic t_table_op random_table_op();
        logic [stff_pkg::FUNC_W-1:0] func;
        int roll;
        roll = $urandom_range(99);
        if (roll < 34) func = stff_pkg::FN_ADD;
        else if (roll < 46) func = stff_pkg::FN_SWAP;
        else if (roll < 60) func = stff_pkg::FN_REPLACE;
        else if (roll < 74) func = stff_pkg::FN_REMOVE;
        else if (roll < 79) func = stff_pkg::FN_CLEAR;
        else if (roll < 95) func = stff_pkg::FN_CHECK;
        else if (roll < 97) func = FN_UNUSED_LO;
        else func = FN_UNUSED_HI;
        return make_op(func, random_handle(), $urandom_range(15), $urandom_range(15));
    endfunction

    // fill the table past full, then half the time clear it with every slot occupied
    task automatic queue_fill_burst();
        int i;
        for (i = 0; i <= TABLE_SLOTS; i++)
            pending_ops.push_back(make_op(stff_pkg::FN_ADD, 16'($urandom_range(65535, 1)),
                                          $urandom_range(15), $urandom_range(15)));
        if ($urandom_range(1)) pending_ops.push_back(make_op(stff_pkg::FN_CLEAR, '0, 0, 0));
    endtask

    task automatic queue_random_ops(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 3) queue_fill_burst();
            else pending_ops.push_back(random_table_op());
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || table_results_due.size() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_notify(logic value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        notify_shadow = value;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, bad add, edge handles, swaps, replaces, odd codes
        pending_ops.push_back(make_op(stff_pkg::FN_CHECK, '0, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_ADD, '0, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_REMOVE, '0, 9, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_ADD, 16'hFFFF, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_ADD, 16'h0001, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_ADD, 16'h8000, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_SWAP, '0, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_SWAP, '0, 1, 15));
        pending_ops.push_back(make_op(stff_pkg::FN_SWAP, '0, 14, 13));
        pending_ops.push_back(make_op(stff_pkg::FN_REPLACE, '0, 15, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_REPLACE, 16'hAAAA, 3, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_REPLACE, 16'h5555, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_REMOVE, '0, 2, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_CHECK, '0, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_CHECK, '0, 15, 15));
        pending_ops.push_back(make_op(FN_UNUSED_LO, '1, 15, 15));
        pending_ops.push_back(make_op(FN_UNUSED_HI, '1, 15, 15));
        pending_ops.push_back(make_op(stff_pkg::FN_ADD, 16'h1234, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_CLEAR, '0, 0, 0));
        pending_ops.push_back(make_op(stff_pkg::FN_CLEAR, '0, 0, 0));
        wait_drained();

        write_notify(1'b0);
        queue_fill_burst();
        queue_random_ops(52);
        wait_drained();

        // a long stretch with no gaps on either side
        write_notify(1'b1);
        no_idle = 1'b1;
        queue_fill_burst();
        queue_random_ops(52);
        wait_drained();
        no_idle = 1'b0;

        // receiver stalls long enough to back the block up into its input
        write_notify(1'b0);
        queue_random_ops(52);
        while (pending_ops.size() > 60) @(negedge i_clk);
        hold_req = 300;
        wait_drained();

        write_notify(1'b1);
        queue_random_ops(52);
        wait_drained();

        if (!mismatch_seen) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
